// ----- hw/rtl/lpp_pkg.sv -----
// ----------------------------------------------------------------------------
// lpp_pkg: shared constants for the lidar point to pixel projection
// Widths of the fixed-point datapath, calibration constants and register codes.
// ----------------------------------------------------------------------------
package lpp_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned CoordW = 32;
  localparam int unsigned ProdW  = 64;
  localparam int unsigned SumW   = 66;
  localparam int unsigned AccW   = 44;
  localparam int unsigned NumW   = 62;
  localparam int unsigned RemW   = 72;
  localparam int unsigned QuotW  = 16;
  localparam int unsigned PixW   = 16;
  localparam int unsigned DimW   = 14;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 64;

  localparam logic signed [NumW-1:0] ScaleNum = NumW'(10000);
  localparam logic signed [NumW-1:0] ScaleDen = NumW'(6848);
  localparam logic signed [NumW-1:0] OfsCol   = NumW'(188868);
  localparam logic signed [NumW-1:0] OfsRow   = NumW'(146651);

  localparam logic [DimW-1:0] WidthReset  = DimW'(1242);
  localparam logic [DimW-1:0] HeightReset = DimW'(375);

  localparam logic [CfgIdxW-1:0] RegRow0A  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegRow0B  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegRow1A  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegRow1B  = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegRow2A  = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegRow2B  = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] RegWidth  = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] RegHeight = CfgIdxW'(7);

endpackage

// ----- hw/rtl/lidar_point_pixel_projection.sv -----
// ----------------------------------------------------------------------------
// lidar_point_pixel_projection: pinhole projection of lidar points to pixels
// 3x4 fixed-point matrix, depth divide, calibration offset and scale,
// visibility test against the image size.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// s_axis    in         s_axis_tvalid/tready     tdata: point_x, point_y, point_z
// m_axis    out        m_axis_tvalid/tready     tdata: pixel_col, pixel_row;
//                                               tuser: visible
// cfg       in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle through 22 register stages while the pipe is not stalled;
// an accepted item runs through the five front stages, then through the
// 16-stage restoring divider, one quotient bit per stage, into the output
// register. All stages advance together whenever the output register is
// empty or being emptied; a stall freezes the whole pipe. Reset clears the
// valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module lidar_point_pixel_projection #(
  parameter int unsigned FRAC_BITS = lpp_pkg::FracBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  input  logic [3*lpp_pkg::CoordW-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // pixel_col [15:0], pixel_row [31:16]
  output logic [2*lpp_pkg::PixW-1:0]   m_axis_tdata,
  // visible [0]
  output logic                         m_axis_tuser,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lpp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CW = lpp_pkg::CoordW;
  localparam int unsigned PW = lpp_pkg::ProdW;
  localparam int unsigned SW = lpp_pkg::SumW;
  localparam int unsigned AW = lpp_pkg::AccW;
  localparam int unsigned NW = lpp_pkg::NumW;
  localparam int unsigned RW = lpp_pkg::RemW;
  localparam int unsigned QW = lpp_pkg::QuotW;
  localparam int unsigned XW = lpp_pkg::PixW;
  localparam int unsigned DW = lpp_pkg::DimW;
  localparam int unsigned NStages = 6 + QW;

  // ---------------- configuration ----------------
  logic [lpp_pkg::CfgDataW-1:0] coef_q [6];
  logic [DW-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) coef_q[i] <= '0;
      width_q  <= lpp_pkg::WidthReset;
      height_q <= lpp_pkg::HeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lpp_pkg::RegRow0A:  coef_q[0] <= cfg_data_i;
        lpp_pkg::RegRow0B:  coef_q[1] <= cfg_data_i;
        lpp_pkg::RegRow1A:  coef_q[2] <= cfg_data_i;
        lpp_pkg::RegRow1B:  coef_q[3] <= cfg_data_i;
        lpp_pkg::RegRow2A:  coef_q[4] <= cfg_data_i;
        lpp_pkg::RegRow2B:  coef_q[5] <= cfg_data_i;
        lpp_pkg::RegWidth:  width_q   <= cfg_data_i[DW-1:0];
        lpp_pkg::RegHeight: height_q  <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic [NStages-1:0] vld_q;
  logic adv;

  assign adv           = !vld_q[NStages-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStages-2:0], s_axis_tvalid};
    end
  end

  // ---------------- stage 1: nine products ----------------
  logic signed [CW-1:0] pt [3];
  logic signed [PW-1:0] prod_q [3][3];
  logic signed [CW-1:0] c3_q [3];
  logic                 ypos1_q;

  assign pt[0] = s_axis_tdata[CW-1:0];
  assign pt[1] = s_axis_tdata[2*CW-1:CW];
  assign pt[2] = s_axis_tdata[3*CW-1:2*CW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[r][0] <= PW'($signed(coef_q[2*r][CW-1:0])) * PW'(pt[0]);
        prod_q[r][1] <= PW'($signed(coef_q[2*r][2*CW-1:CW])) * PW'(pt[1]);
        prod_q[r][2] <= PW'($signed(coef_q[2*r+1][CW-1:0])) * PW'(pt[2]);
        c3_q[r]      <= $signed(coef_q[2*r+1][2*CW-1:CW]);
      end
      ypos1_q <= !pt[1][CW-1];
    end
  end

  // ---------------- stage 2: floor, sum, saturate ----------------
  logic signed [AW-1:0] acc_q [3];
  logic                 ypos2_q;
  logic signed [SW-1:0] sum [3];
  localparam logic signed [SW-1:0] AccMax = SW'({1'b0, {(AW-1){1'b1}}});
  localparam logic signed [SW-1:0] AccMin = -AccMax - SW'(1);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SW'(prod_q[r][0] >>> FRAC_BITS) + SW'(prod_q[r][1] >>> FRAC_BITS)
             + SW'(prod_q[r][2] >>> FRAC_BITS) + SW'(c3_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        if (sum[r] > AccMax)      acc_q[r] <= AccMax[AW-1:0];
        else if (sum[r] < AccMin) acc_q[r] <= AccMin[AW-1:0];
        else                      acc_q[r] <= sum[r][AW-1:0];
      end
      ypos2_q <= ypos1_q;
    end
  end

  // ---------------- stage 3: numerators and denominator ----------------
  logic signed [NW-1:0] numc_q, numr_q, den3_q;
  logic                 ypos3_q, wpos3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numc_q  <= lpp_pkg::ScaleNum * NW'(acc_q[0]) + lpp_pkg::OfsCol * NW'(acc_q[2]);
      numr_q  <= lpp_pkg::ScaleNum * NW'(acc_q[1]) + lpp_pkg::OfsRow * NW'(acc_q[2]);
      den3_q  <= lpp_pkg::ScaleDen * NW'(acc_q[2]);
      wpos3_q <= (acc_q[2] > 0);
      ypos3_q <= ypos2_q;
    end
  end

  // ---------------- stage 4: magnitudes ----------------
  logic [NW-1:0] magc_q, magr_q, den4_q;
  logic          negc4_q, negr4_q, ypos4_q, wpos4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      magc_q  <= numc_q[NW-1] ? NW'(-numc_q) : NW'(numc_q);
      magr_q  <= numr_q[NW-1] ? NW'(-numr_q) : NW'(numr_q);
      negc4_q <= numc_q[NW-1];
      negr4_q <= numr_q[NW-1];
      den4_q  <= den3_q;
      wpos4_q <= wpos3_q;
      ypos4_q <= ypos3_q;
    end
  end

  // ---------------- stage 5: overflow check ----------------
  // Quotient magnitude of 2^QW or more saturates either way.
  logic [RW-1:0] remc_q [QW+1];
  logic [RW-1:0] remr_q [QW+1];
  logic [RW-1:0] dden_q [QW+1];
  logic [QW-1:0] qc_q   [QW+1];
  logic [QW-1:0] qr_q   [QW+1];
  logic          ovfc_q [QW+1];
  logic          ovfr_q [QW+1];
  logic          negc_q [QW+1];
  logic          negr_q [QW+1];
  logic          wpos_q [QW+1];
  logic          ypos_q [QW+1];
  logic [RW-1:0] den_top;

  assign den_top = RW'(den4_q) << QW;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      remc_q[0] <= RW'(magc_q);
      remr_q[0] <= RW'(magr_q);
      dden_q[0] <= RW'(den4_q);
      qc_q[0]   <= '0;
      qr_q[0]   <= '0;
      ovfc_q[0] <= (RW'(magc_q) >= den_top);
      ovfr_q[0] <= (RW'(magr_q) >= den_top);
      negc_q[0] <= negc4_q;
      negr_q[0] <= negr4_q;
      wpos_q[0] <= wpos4_q;
      ypos_q[0] <= ypos4_q;
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW-1:0] sh;
    logic          gec, ger;
    assign sh  = dden_q[k] << (QW - 1 - k);
    assign gec = (remc_q[k] >= sh);
    assign ger = (remr_q[k] >= sh);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        remc_q[k+1] <= gec ? remc_q[k] - sh : remc_q[k];
        remr_q[k+1] <= ger ? remr_q[k] - sh : remr_q[k];
        qc_q[k+1]   <= {qc_q[k][QW-2:0], gec};
        qr_q[k+1]   <= {qr_q[k][QW-2:0], ger};
        dden_q[k+1] <= dden_q[k];
        ovfc_q[k+1] <= ovfc_q[k];
        ovfr_q[k+1] <= ovfr_q[k];
        negc_q[k+1] <= negc_q[k];
        negr_q[k+1] <= negr_q[k];
        wpos_q[k+1] <= wpos_q[k];
        ypos_q[k+1] <= ypos_q[k];
      end
    end
  end

  // ---------------- output stage: sign, saturate, visibility ----------------
  function automatic logic signed [XW-1:0] apply_sign(input logic [QW-1:0] mag,
                                                      input logic ovf,
                                                      input logic neg);
    logic signed [QW+1:0] s;
    s = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    if (neg) begin
      if (ovf || s < -(QW+2)'(32768)) return {1'b1, {(XW-1){1'b0}}};
    end else begin
      if (ovf || s > (QW+2)'(32767)) return {1'b0, {(XW-1){1'b1}}};
    end
    return s[XW-1:0];
  endfunction

  logic signed [XW-1:0] col, row;
  logic                 vis;

  always_comb begin
    col = '0;
    row = '0;
    vis = 1'b0;
    if (wpos_q[QW]) begin
      col = apply_sign(qc_q[QW], ovfc_q[QW], negc_q[QW]);
      row = apply_sign(qr_q[QW], ovfr_q[QW], negr_q[QW]);
      vis = ypos_q[QW] && !col[XW-1] && ($signed({1'b0, col}) < $signed({1'b0, 3'b000, width_q}))
          && !row[XW-1] && (row != '0)
          && ($signed({1'b0, row}) < $signed({1'b0, 3'b000, height_q}));
    end
  end

  logic [2*XW-1:0] tdata_q;
  logic            tuser_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdata_q <= {row, col};
      tuser_q <= vis;
    end
  end

  assign m_axis_tdata = tdata_q;
  assign m_axis_tuser = tuser_q;

endmodule

// ----- hw/rtl/lpp_checker.sv -----
// ----------------------------------------------------------------------------
// lpp_checker: port-level checks for the pixel projection block
// Watches the stream ports and the configuration port over time.
// ----------------------------------------------------------------------------
module lpp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [2*lpp_pkg::PixW-1:0]   m_axis_tdata,
  input logic                         m_axis_tuser,
  input logic                         cfg_ready_o
);

  // a free or draining output register lets a new item in
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while output register free");

  // a visible pixel lies inside the image: non-negative column, positive row
  a_vis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (!m_axis_tdata[15] && !m_axis_tdata[31] && m_axis_tdata[31:16] != 16'd0))
    else $error("visible flag on pixel outside image");

  // hold the item while the sink stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output item changed under stall");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind lidar_point_pixel_projection lpp_checker u_lpp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_ready_o   (cfg_ready_o)
);
